// ----- rtl/core/spiral_position_to_coordinate_assert.svh -----
// assertion macros for the spiral position to coordinate block
`ifndef SPIRAL_POSITION_TO_COORDINATE_ASSERT_SVH
`define SPIRAL_POSITION_TO_COORDINATE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/spc_pkg.sv -----
// shared types and constants for the spiral position to coordinate block
package spc_pkg;

	localparam int MAX_SIZE_DEF = 64;
	localparam int GRID_W = 7;
	localparam int POS_W = 16;
	localparam int COORD_W = 6;
	localparam logic [GRID_W-1:0] GRID_RESET = 7'd4;

	typedef enum logic [1:0] {
		ST_MORE   = 2'd0,
		ST_LAST   = 2'd1,
		ST_BEYOND = 2'd2
	} status_t;

	typedef enum logic {
		CS_IDLE,
		CS_WALK
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic publish;
	} spc_cmd_t;

	typedef struct packed {
		logic done;
	} spc_stat_t;

endpackage

// ----- rtl/core/spc_ctrl.sv -----
// controller state machine: item intake, ring walk sequencing and result handoff
module spc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  spc_pkg::spc_stat_t stat,
	output spc_pkg::spc_cmd_t  cmd
);
	import spc_pkg::*;

	ctrl_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = CS_WALK;
				end
			end
			CS_WALK: begin
				cmd.step = 1'b1;
				if (stat.done && out_free) begin
					cmd.publish = 1'b1;
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/spc_datapath.sv -----
// datapath: grid size register, ring walk registers and result register
module spc_datapath #(
	parameter int MAX_SIZE = spc_pkg::MAX_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [spc_pkg::GRID_W-1:0]   cfg_wr_data,
	input  logic [spc_pkg::POS_W-1:0]    position,
	input  spc_pkg::spc_cmd_t            cmd,
	output spc_pkg::spc_stat_t           stat,
	output logic [spc_pkg::COORD_W-1:0]  row,
	output logic [spc_pkg::COORD_W-1:0]  column,
	output logic [1:0]                   status,
	output logic [spc_pkg::POS_W-1:0]    distance
);
	import spc_pkg::*;

	localparam int SW = $clog2(MAX_SIZE + 1);
	localparam int CW = (2 * SW > POS_W) ? 2 * SW : POS_W;
	localparam int XW = (SW > GRID_W) ? SW + 1 : GRID_W + 1;

	logic [GRID_W-1:0] grid_q;
	logic [XW-1:0] grid_x;
	logic [SW-1:0] side;

	logic [CW-1:0] pos_q, total_q, q_q;
	logic [SW-1:0] s_q, r_q;

	logic [CW-1:0] e, e2, e3, e4, rr;
	logic skip, done;
	logic [CW-1:0] row_c, col_c;

	logic [COORD_W-1:0] row_q, col_q;
	status_t status_q;
	logic [POS_W-1:0] dist_q;
	status_t status_c;
	logic [CW-1:0] dist_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= GRID_RESET;
		end else if (cfg_wr_en) begin
			grid_q <= cfg_wr_data;
		end
	end

	// effective side: zero reads as one, large values saturate
	assign grid_x = XW'(grid_q);
	always_comb begin
		priority if (grid_q == '0) begin
			side = SW'(1);
		end else if (grid_x > XW'(MAX_SIZE)) begin
			side = SW'(MAX_SIZE);
		end else begin
			side = SW'(grid_x);
		end
	end

	assign e  = CW'(s_q) - CW'(1);
	assign e2 = e << 1;
	assign e3 = e2 + e;
	assign e4 = e << 2;
	assign rr = CW'(r_q);
	assign skip = (pos_q == '0) || (pos_q > total_q);

	always_comb begin
		done = 1'b1;
		row_c = '0;
		col_c = '0;
		priority if (skip || s_q == '0) begin
			row_c = '0;
		end else if (s_q == SW'(1)) begin
			row_c = rr;
			col_c = rr;
		end else if (q_q < e) begin
			row_c = rr;
			col_c = rr + q_q;
		end else if (q_q < e2) begin
			row_c = rr + q_q - e;
			col_c = rr + e;
		end else if (q_q < e3) begin
			row_c = rr + e;
			col_c = rr + e3 - q_q;
		end else if (q_q < e4) begin
			row_c = rr + e4 - q_q;
			col_c = rr;
		end else begin
			done = 1'b0;
		end
	end

	assign stat.done = done;

	always_comb begin
		priority if (pos_q > total_q) begin
			status_c = ST_BEYOND;
			dist_c = pos_q - total_q;
		end else if (pos_q == total_q) begin
			status_c = ST_LAST;
			dist_c = '0;
		end else begin
			status_c = ST_MORE;
			dist_c = total_q - pos_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q <= CW'(position);
			q_q <= CW'(position) - CW'(1);
			total_q <= CW'(side) * CW'(side);
			s_q <= side;
			r_q <= '0;
		end else if (cmd.step && !done) begin
			q_q <= q_q - e4;
			s_q <= s_q - SW'(2);
			r_q <= r_q + SW'(1);
		end
		if (cmd.publish) begin
			row_q <= row_c[COORD_W-1:0];
			col_q <= col_c[COORD_W-1:0];
			status_q <= status_c;
			dist_q <= dist_c[POS_W-1:0];
		end
	end

	assign row = row_q;
	assign column = col_q;
	assign status = status_q;
	assign distance = dist_q;

endmodule

// ----- rtl/core/spiral_position_to_coordinate.sv -----
// top level: spiral position to row and column lookup
//
// channel   direction  handshake              payload
// cfg       in         cfg_wr_en              cfg_wr_data (grid_size)
// in        in         in_valid / in_ready    position
// out       out        out_valid / out_ready  row, column, status, distance
//
// the result loads once the walk has skipped k rings to reach the ring that holds the position
// and the output is free (k at most 31 for a 64 wide grid); one ring per cycle
// in_ready is high only while idle; the next item is taken the cycle after the result loads
// the result register holds while out_ready is low; a finished walk waits for it to free
// reset clears the control state and sets the grid side to 4
module spiral_position_to_coordinate #(
	parameter int MAX_SIZE = spc_pkg::MAX_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [spc_pkg::GRID_W-1:0]   cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [spc_pkg::POS_W-1:0]    position,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [spc_pkg::COORD_W-1:0]  row,
	output logic [spc_pkg::COORD_W-1:0]  column,
	output logic [1:0]                   status,
	output logic [spc_pkg::POS_W-1:0]    distance
);
	import spc_pkg::*;

	spc_cmd_t cmd;
	spc_stat_t stat;

	spc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	spc_datapath #(
		.MAX_SIZE (MAX_SIZE)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.position    (position),
		.cmd         (cmd),
		.stat        (stat),
		.row         (row),
		.column      (column),
		.status      (status),
		.distance    (distance)
	);

`include "spiral_position_to_coordinate_assert.svh"

	`SPC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item taken while walking")
	`SPC_ASSERT_NOW(a_result_from_walk, $rose(out_valid), !$past(in_ready), "result without a walk")
	`SPC_ASSERT_NOW(a_last_zero_dist, out_valid && status == ST_LAST, distance == '0, "last cell with nonzero distance")
	`SPC_ASSERT_NOW(a_beyond_origin, out_valid && status == ST_BEYOND, row == '0 && column == '0, "beyond grid with nonzero coordinate")

endmodule

// ----- verif/spiral_position_to_coordinate_check.sv -----
// checker for the spiral position to coordinate block: predicts each result item and compares it
module spiral_position_to_coordinate_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [spc_pkg::GRID_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [spc_pkg::POS_W-1:0]   position,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [spc_pkg::COORD_W-1:0] row,
	input  logic [spc_pkg::COORD_W-1:0] column,
	input  logic [1:0]                  status,
	input  logic [spc_pkg::POS_W-1:0]   distance,
	output int                          fail_count,
	output int                          pending,
	output int                          checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import spc_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] column;
		status_t            status;
		logic [POS_W-1:0]   distance;
	} spot_t;

	spot_t spots_due[$];
	logic [GRID_W-1:0] side_code;

	function automatic spot_t locate_spot(input logic [GRID_W-1:0] code,
		input logic [POS_W-1:0] p);
		spot_t spot;
		int unsigned n, total, q, ring, span, leg, r, c;
		bit found;
		n = code;
		if (n == 0) n = 1;
		if (n > MAX_SIZE_DEF) n = MAX_SIZE_DEF;
		total = n * n;
		spot = '0;
		r = 0;
		c = 0;
		if (p > total) begin
			spot.status = ST_BEYOND;
			spot.distance = POS_W'(p - total);
		end else begin
			spot.status = (p == total) ? ST_LAST : ST_MORE;
			spot.distance = POS_W'(total - p);
			if (p != 0) begin
				q = p - 1;
				ring = 0;
				found = 0;
				while (2 * ring < n && !found) begin
					span = n - 2 * ring;
					leg = span - 1;
					if (span == 1) begin
						r = ring;
						c = ring;
						found = 1;
					end else if (q < 4 * leg) begin
						if (q < leg) begin
							r = ring;
							c = ring + q;
						end else if (q < 2 * leg) begin
							r = ring + (q - leg);
							c = ring + leg;
						end else if (q < 3 * leg) begin
							r = ring + leg;
							c = ring + leg - (q - 2 * leg);
						end else begin
							r = ring + leg - (q - 3 * leg);
							c = ring;
						end
						found = 1;
					end else begin
						q -= 4 * leg;
						ring++;
					end
				end
			end
		end
		spot.row = COORD_W'(r);
		spot.column = COORD_W'(c);
		return spot;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < 20)
			$display("%0t ns: mismatch on %s, got %0d, want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		spot_t due;
		if (!arst_n) begin
			side_code <= GRID_RESET;
			spots_due.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (cfg_wr_en)
				side_code <= cfg_wr_data;
			if (out_valid && out_ready) begin
				if (spots_due.size() == 0) begin
					report_mismatch("item with nothing due, row", row, 0);
				end else begin
					due = spots_due.pop_front();
					if (row !== due.row)
						report_mismatch("row", row, due.row);
					if (column !== due.column)
						report_mismatch("column", column, due.column);
					if (status !== due.status)
						report_mismatch("status", status, due.status);
					if (distance !== due.distance)
						report_mismatch("distance", distance, due.distance);
					checked++;
				end
			end
			if (in_valid && in_ready)
				spots_due.push_back(locate_spot(side_code, position));
			pending = spots_due.size();
		end
	end

endmodule

// ----- verif/spiral_position_to_coordinate_test.sv -----
// testbench top for the spiral position to coordinate block: stimulus, flow control and verdict
module spiral_position_to_coordinate_test;
	timeunit 1ns;
	timeprecision 1ps;
	import spc_pkg::*;

	localparam int PHASES = 14;
	localparam int PER_PHASE = 36;
	localparam int HOLD_CYCLES = 400;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [GRID_W-1:0]  cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic [POS_W-1:0]   position;
	logic               out_valid;
	logic               out_ready;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] column;
	logic [1:0]         status;
	logic [POS_W-1:0]   distance;

	int fail_count;
	int pending;
	int checked;
	int sent;
	int hold_asks;
	bit calm;

	spiral_position_to_coordinate dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.position    (position),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.row         (row),
		.column      (column),
		.status      (status),
		.distance    (distance)
	);

	spiral_position_to_coordinate_check check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.position    (position),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.row         (row),
		.column      (column),
		.status      (status),
		.distance    (distance),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("spiral_position_to_coordinate regression: fail");
		$finish;
	end

	function automatic int cell_count(input logic [GRID_W-1:0] code);
		int n;
		n = code;
		if (n == 0) n = 1;
		if (n > MAX_SIZE_DEF) n = MAX_SIZE_DEF;
		return n * n;
	endfunction

	// mostly cells on the grid, some zero, last, past the end and full 16-bit values
	function automatic logic [POS_W-1:0] pick_position(input int total);
		int r;
		r = $urandom_range(99, 0);
		if (r < 65)
			return POS_W'($urandom_range(total, 1));
		else if (r < 75)
			return r[0] ? POS_W'(total) : '0;
		else if (r < 88)
			return POS_W'($urandom_range(65535, total + 1));
		else
			return POS_W'($urandom_range(65535, 0));
	endfunction

	task automatic send_position(input logic [POS_W-1:0] p);
		while (!calm && $urandom_range(99, 0) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		position <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_side(input logic [GRID_W-1:0] code);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= code;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// receiver: random stalls, a calm stretch, and one long hold on request
	initial begin
		int holds_served;
		int k;
		holds_served = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks != holds_served) begin
				out_ready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
				holds_served++;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99, 0) >= 16);
			end
		end
	end

	initial begin
		int opening[16];
		int sides[PHASES];
		int i;
		int j;
		int total;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		position = '0;
		sent = 0;
		hold_asks = 0;
		calm = 0;
		opening = '{0, 1, 2, 4, 5, 7, 8, 10, 11, 12, 13, 15, 16, 17, 40000, 65535};
		sides = '{1, 64, 0, 127, 2, 3, 7, 64, 33, 16, 0, 0, 0, 0};
		for (i = 10; i < PHASES; i++)
			sides[i] = $urandom_range(MAX_SIZE_DEF, 1);
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// grid side at its reset value: each edge, corners, inner ring, bounds
		foreach (opening[i])
			send_position(POS_W'(opening[i]));

		for (i = 0; i < PHASES; i++) begin
			wait_drained();
			write_side(GRID_W'(sides[i]));
			total = cell_count(GRID_W'(sides[i]));
			calm = (i == 8);
			if (i == 7)
				hold_asks++;
			send_position(POS_W'(total));
			send_position(POS_W'(total + 1));
			for (j = 0; j < PER_PHASE; j++)
				send_position(pick_position(total));
		end
		calm = 0;

		wait_drained();
		repeat (40) @(negedge clk);
		$display("%0d positions sent, %0d results checked over %0d grid sides", sent, checked,
			PHASES + 1);
		$display("side codes 0 and 127 included; one %0d-cycle output hold filled the block",
			HOLD_CYCLES);
		if (fail_count == 0)
			$display("spiral_position_to_coordinate regression: pass");
		else
			$display("spiral_position_to_coordinate regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/spc_pkg.sv
rtl/core/spc_ctrl.sv
rtl/core/spc_datapath.sv
rtl/core/spiral_position_to_coordinate.sv
verif/spiral_position_to_coordinate_check.sv
verif/spiral_position_to_coordinate_test.sv
